>>> hw/rtl/pesm_pkg.sv
// Shared constants, codes and types for the paced echo sweep matcher.
// No dependencies; imported by every module of the block except pesm_stamp_ram.
`default_nettype none

package pesm_pkg;

    localparam int MAX_HOSTS = 256;
    localparam int IDX_W     = $clog2(MAX_HOSTS);

    localparam logic [2:0] ACT_POLL    = 3'd0;
    localparam logic [2:0] ACT_OUTCOME = 3'd1;
    localparam logic [2:0] ACT_REPLY   = 3'd2;
    localparam logic [2:0] ACT_START   = 3'd3;
    localparam logic [2:0] ACT_STOP    = 3'd4;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_SEND  = 2'd1;
    localparam logic [1:0] KIND_ALIVE = 2'd2;

    localparam logic [2:0] CFG_BASE_ADDR   = 3'd0;
    localparam logic [2:0] CFG_HOST_COUNT  = 3'd1;
    localparam logic [2:0] CFG_BATCH_SIZE  = 3'd2;
    localparam logic [2:0] CFG_PACE_MS     = 3'd3;
    localparam logic [2:0] CFG_RETRY_LIMIT = 3'd4;
    localparam logic [2:0] CFG_LINGER_MS   = 3'd5;

    localparam logic [31:0] RST_BASE_ADDR   = 32'd0;
    localparam logic [8:0]  RST_HOST_COUNT  = 9'd254;
    localparam logic [6:0]  RST_BATCH_SIZE  = 7'd12;
    localparam logic [15:0] RST_PACE_MS     = 16'd20;
    localparam logic [3:0]  RST_RETRY_LIMIT = 4'd3;
    localparam logic [15:0] RST_LINGER_MS   = 16'd1400;

    localparam logic [15:0] PROBE_IDENT = 16'h4E45;
    localparam logic [13:0] RTT_CAP     = 14'd9999;
    localparam logic [7:0]  IHL_MASK    = 8'h0F;
    localparam logic [9:0]  INDEX_SAT   = 10'd511;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic [7:0]  length;
        logic [7:0]  ver_ihl;
        logic [7:0]  icmp_type;
        logic [15:0] ident;
        logic [15:0] seq;
    } rx_hdr_t;

endpackage

`default_nettype wire

>>> hw/rtl/pesm_stamp_ram.sv
// Single-port-write, single-port-read synchronous RAM, registered read data.
// Generic; holds the per-host send timestamps.
`default_nettype none

module pesm_stamp_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/pesm_reply_check.sv
// Echo reply header validation: length, version, header length, type, ident, seq.
// Depends on pesm_pkg.
`default_nettype none

module pesm_reply_check (
    input  wire pesm_pkg::rx_hdr_t hdr,
    input  wire logic [8:0]        hosts,
    output logic                   match
);

    import pesm_pkg::*;

    logic [5:0] hdr_bytes;
    logic [8:0] need_len;

    always_comb
    begin
        hdr_bytes = {(hdr.ver_ihl[3:0] & IHL_MASK[3:0]), 2'b00};
        need_len  = 9'(hdr_bytes) + 9'd8;
        match = (hdr.length >= 8'd20) &&
                (hdr.ver_ihl[7:4] == 4'd4) &&
                (hdr_bytes >= 6'd20) &&
                ({1'b0, hdr.length} >= need_len) &&
                (hdr.icmp_type == 8'd0) &&
                (hdr.ident == PROBE_IDENT) &&
                (hdr.seq < 16'(hosts));
    end

endmodule

`default_nettype wire

>>> hw/rtl/paced_echo_sweep_matcher.sv
// Paced echo sweep with reply matcher, top level.
// Sequencing: an accepted word moves the state to ST_EXEC, and result_strobe is registered from ST_EXEC.
// A new word is not taken while busy (ST_EXEC); the stamp RAM is read on accept and written back in ST_EXEC.
// Reset: control state and config registers reset at once; stamp RAM is not cleared.
// The receiver cannot stall; each result is shown for one cycle only.
// Depends on pesm_pkg, pesm_stamp_ram, pesm_reply_check.
`default_nettype none

module paced_echo_sweep_matcher (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  action,
    input  wire logic [31:0] now_ms,
    input  wire logic        send_ok,
    input  wire logic [7:0]  rx_length,
    input  wire logic [7:0]  rx_ver_ihl,
    input  wire logic [7:0]  rx_ttl,
    input  wire logic [7:0]  rx_type,
    input  wire logic [15:0] rx_ident,
    input  wire logic [15:0] rx_seq,
    input  wire logic [31:0] rx_from,
    output logic             result_strobe,
    output logic [1:0]       result_kind,
    output logic [7:0]       host_index,
    output logic [31:0]      target_addr,
    output logic [13:0]      rtt_ms,
    output logic [7:0]       reply_ttl,
    output logic             sweep_done,
    output logic [15:0]      hit_count,
    output logic [8:0]       sent_count
);

    import pesm_pkg::*;

    // config
    logic [31:0] base_addr_reg;
    logic [8:0]  host_count_reg;
    logic [6:0]  batch_size_reg;
    logic [15:0] pace_ms_reg;
    logic [3:0]  retry_limit_reg;
    logic [15:0] linger_ms_reg;

    // sequencer
    state_t state_reg, state_next;
    logic   accept;
    logic   strobe_reg, strobe_next;

    // captured word
    logic [2:0]  act_reg;
    logic [31:0] now_reg;
    logic        ok_reg;
    logic [7:0]  ttl_in_reg;
    logic [31:0] from_reg;
    rx_hdr_t     rx_reg;

    // sweep state
    logic        active_reg, active_next;
    logic [8:0]  next_index_reg, next_index_next;
    logic [3:0]  refusal_reg, refusal_next;
    logic [31:0] next_batch_reg, next_batch_next;
    logic [31:0] linger_end_reg, linger_end_next;
    logic        armed_reg, armed_next;
    logic        open_reg, open_next;
    logic [8:0]  batch_end_reg, batch_end_next;
    logic [8:0]  sent_reg, sent_next;
    logic [15:0] hit_reg, hit_next;
    // entries below the fill count hold a stamp since start
    logic [8:0]  fill_reg, fill_next;

    // result registers
    logic [1:0]  kind_reg, kind_next;
    logic [7:0]  idx_reg, idx_next;
    logic [31:0] addr_reg, addr_next;
    logic [13:0] rtt_reg, rtt_next;
    logic [7:0]  rttl_reg, rttl_next;

    logic [8:0]  hosts;
    logic        reply_match;
    logic [31:0] stamp_rd;
    logic        ram_we;
    logic [8:0]  issue_idx;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] raddr;

    logic [6:0]  batch_eff;
    logic [9:0]  batch_sum;
    logic [8:0]  index_inc;
    logic [3:0]  refusal_inc;
    logic        advance;
    logic        do_issue;
    logic [31:0] rtt_diff;
    logic [31:0] stamp_eff;

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg == ST_EXEC);
    assign accept    = start && !busy;
    assign hosts     = (int'(host_count_reg) < MAX_HOSTS) ? host_count_reg : 9'(MAX_HOSTS);
    assign waddr     = IDX_W'(issue_idx);
    assign raddr     = IDX_W'(rx_seq);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_addr_reg   <= RST_BASE_ADDR;
            host_count_reg  <= RST_HOST_COUNT;
            batch_size_reg  <= RST_BATCH_SIZE;
            pace_ms_reg     <= RST_PACE_MS;
            retry_limit_reg <= RST_RETRY_LIMIT;
            linger_ms_reg   <= RST_LINGER_MS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BASE_ADDR:   base_addr_reg   <= cfg_data;
                CFG_HOST_COUNT:  host_count_reg  <= cfg_data[8:0];
                CFG_BATCH_SIZE:  batch_size_reg  <= cfg_data[6:0];
                CFG_PACE_MS:     pace_ms_reg     <= cfg_data[15:0];
                CFG_RETRY_LIMIT: retry_limit_reg <= cfg_data[3:0];
                CFG_LINGER_MS:   linger_ms_reg   <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg           <= action;
            now_reg           <= now_ms;
            ok_reg            <= send_ok;
            ttl_in_reg        <= rx_ttl;
            from_reg          <= rx_from;
            rx_reg.length     <= rx_length;
            rx_reg.ver_ihl    <= rx_ver_ihl;
            rx_reg.icmp_type  <= rx_type;
            rx_reg.ident      <= rx_ident;
            rx_reg.seq        <= rx_seq;
        end
    end

    pesm_stamp_ram #(
        .DEPTH (MAX_HOSTS),
        .WIDTH (32)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (now_reg),
        .re    (accept),
        .raddr (raddr),
        .rdata (stamp_rd)
    );

    pesm_reply_check u_reply_check (
        .hdr   (rx_reg),
        .hosts (hosts),
        .match (reply_match)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            strobe_reg     <= 1'b0;
            active_reg     <= 1'b0;
            next_index_reg <= '0;
            refusal_reg    <= '0;
            next_batch_reg <= '0;
            linger_end_reg <= '0;
            armed_reg      <= 1'b0;
            open_reg       <= 1'b0;
            batch_end_reg  <= '0;
            sent_reg       <= '0;
            hit_reg        <= '0;
            fill_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            strobe_reg     <= strobe_next;
            active_reg     <= active_next;
            next_index_reg <= next_index_next;
            refusal_reg    <= refusal_next;
            next_batch_reg <= next_batch_next;
            linger_end_reg <= linger_end_next;
            armed_reg      <= armed_next;
            open_reg       <= open_next;
            batch_end_reg  <= batch_end_next;
            sent_reg       <= sent_next;
            hit_reg        <= hit_next;
            fill_reg       <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        idx_reg  <= idx_next;
        addr_reg <= addr_next;
        rtt_reg  <= rtt_next;
        rttl_reg <= rttl_next;
    end

    function automatic logic next_batch_diff_msb(input logic [31:0] now_v,
                                                 input logic [31:0] when_v);
        logic [31:0] d;
        d = now_v - when_v;
        return d[31];
    endfunction

    always_comb
    begin
        state_next      = state_reg;
        strobe_next     = 1'b0;
        active_next     = active_reg;
        next_index_next = next_index_reg;
        refusal_next    = refusal_reg;
        next_batch_next = next_batch_reg;
        linger_end_next = linger_end_reg;
        armed_next      = armed_reg;
        open_next       = open_reg;
        batch_end_next  = batch_end_reg;
        sent_next       = sent_reg;
        hit_next        = hit_reg;
        fill_next       = fill_reg;
        do_issue        = 1'b0;
        issue_idx       = next_index_reg;
        kind_next       = kind_reg;
        idx_next        = idx_reg;
        addr_next       = addr_reg;
        rtt_next        = rtt_reg;
        rttl_next       = rttl_reg;

        batch_eff   = (batch_size_reg == 7'd0) ? 7'd1 : batch_size_reg;
        batch_sum   = 10'(next_index_reg) + 10'(batch_eff);
        index_inc   = next_index_reg + 9'd1;
        refusal_inc = refusal_reg + 4'd1;
        advance     = ok_reg || (refusal_inc >= retry_limit_reg);
        stamp_eff   = (rx_reg.seq < 16'(fill_reg)) ? stamp_rd : 32'd0;
        rtt_diff    = now_reg - stamp_eff;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next  = ST_IDLE;
                strobe_next = 1'b1;
                kind_next   = KIND_NONE;
                idx_next    = '0;
                addr_next   = '0;
                rtt_next    = '0;
                rttl_next   = '0;
                case (act_reg)
                    ACT_START:
                    begin
                        active_next     = 1'b1;
                        next_index_next = '0;
                        refusal_next    = '0;
                        next_batch_next = now_reg;
                        linger_end_next = '0;
                        armed_next      = 1'b0;
                        open_next       = 1'b0;
                        batch_end_next  = '0;
                        sent_next       = '0;
                        hit_next        = '0;
                        fill_next       = '0;
                    end
                    ACT_STOP:
                    begin
                        active_next = 1'b0;
                        open_next   = 1'b0;
                    end
                    ACT_POLL:
                    begin
                        if (active_reg && !open_reg)
                        begin
                            if (next_index_reg >= hosts)
                            begin
                                if (!armed_reg)
                                begin
                                    linger_end_next = now_reg + 32'(linger_ms_reg);
                                    armed_next      = 1'b1;
                                end
                            end
                            else if (!next_batch_diff_msb(now_reg, next_batch_reg))
                            begin
                                next_batch_next = now_reg + 32'(pace_ms_reg);
                                batch_end_next  = (batch_sum > INDEX_SAT) ?
                                                  INDEX_SAT[8:0] : batch_sum[8:0];
                                do_issue        = 1'b1;
                                issue_idx       = next_index_reg;
                            end
                        end
                    end
                    ACT_OUTCOME:
                    begin
                        if (active_reg && open_reg)
                        begin
                            open_next = 1'b0;
                            if (!advance)
                            begin
                                refusal_next = refusal_inc;
                            end
                            else
                            begin
                                refusal_next    = '0;
                                next_index_next = index_inc;
                                sent_next       = sent_reg + 9'd1;
                                if (index_inc >= hosts)
                                begin
                                    linger_end_next = now_reg + 32'(linger_ms_reg);
                                    armed_next      = 1'b1;
                                end
                                else if (index_inc < batch_end_reg)
                                begin
                                    do_issue  = 1'b1;
                                    issue_idx = index_inc;
                                end
                            end
                        end
                    end
                    ACT_REPLY:
                    begin
                        if (active_reg && reply_match)
                        begin
                            kind_next = KIND_ALIVE;
                            idx_next  = rx_reg.seq[7:0];
                            addr_next = from_reg;
                            rttl_next = ttl_in_reg;
                            if (rtt_diff > 32'(RTT_CAP))
                            begin
                                rtt_next = RTT_CAP;
                            end
                            else if (rtt_diff == 32'd0)
                            begin
                                rtt_next = 14'd1;
                            end
                            else
                            begin
                                rtt_next = rtt_diff[13:0];
                            end
                            if (hit_reg != 16'hFFFF)
                            begin
                                hit_next = hit_reg + 16'd1;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (do_issue)
                begin
                    open_next = 1'b1;
                    fill_next = issue_idx + 9'd1;
                    kind_next = KIND_SEND;
                    idx_next  = issue_idx[7:0];
                    addr_next = base_addr_reg + 32'(issue_idx);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        ram_we = do_issue;
    end

    // status is read from the updated state while the result is shown
    always_comb
    begin
        logic [31:0] ldiff;
        ldiff      = now_reg - linger_end_reg;
        sweep_done = !active_reg ||
                     ((next_index_reg >= hosts) && armed_reg && !ldiff[31]);
    end

    assign result_strobe = strobe_reg;
    assign result_kind   = kind_reg;
    assign host_index    = idx_reg;
    assign target_addr   = addr_reg;
    assign rtt_ms        = rtt_reg;
    assign reply_ttl     = rttl_reg;
    assign hit_count     = hit_reg;
    assign sent_count    = sent_reg;

endmodule

`default_nettype wire

>>> hw/rtl/pesm_checker.sv
// Port-level assertions for the paced echo sweep matcher, bound to the top level.
// Depends on pesm_pkg and paced_echo_sweep_matcher.
`default_nettype none

module pesm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        result_strobe,
    input wire logic [1:0]  result_kind,
    input wire logic [7:0]  host_index,
    input wire logic [31:0] target_addr,
    input wire logic [13:0] rtt_ms,
    input wire logic [7:0]  reply_ttl
);

    import pesm_pkg::*;

    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    a_busy_then_result: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> result_strobe && !busy)
        else $error("busy cycle not followed by a result");

    a_result_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(busy))
        else $error("result without an accepted word");

    a_alive_rtt_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result_kind == KIND_ALIVE |-> rtt_ms >= 14'd1 && rtt_ms <= RTT_CAP)
        else $error("round trip out of range on report");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result_kind == KIND_NONE |->
            host_index == 8'd0 && target_addr == 32'd0 && rtt_ms == 14'd0 && reply_ttl == 8'd0)
        else $error("empty result carries payload");

endmodule

bind paced_echo_sweep_matcher pesm_checker u_pesm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .result_strobe (result_strobe),
    .result_kind   (result_kind),
    .host_index    (host_index),
    .target_addr   (target_addr),
    .rtt_ms        (rtt_ms),
    .reply_ttl     (reply_ttl)
);

`default_nettype wire
